// File: rtl/core/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and helper functions for the bit set pair counter.
// ----------------------------------------------------------------------------
package bpp_pkg;

  // largest bit set length in 64-bit words
  localparam int unsigned MAX_WORDS       = 64;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned BYTES_PER_WORD  = WORD_W / 8;
  localparam int unsigned VBYTES_W        = 4;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned COUNT_LIMIT     = (MAX_WORDS * WORD_W > COUNT_FIELD_MAX) ?
                                            COUNT_FIELD_MAX : MAX_WORDS * WORD_W;
  // ones in one word: 0..64
  localparam int unsigned ONES_W          = 7;
  localparam int unsigned MODE_W          = 3;

  // bitwise operation selected by the mode register
  typedef enum logic [MODE_W-1:0] {
    MODE_AND  = 3'd0,
    MODE_OR   = 3'd1,
    MODE_XNOR = 3'd2,
    MODE_XOR  = 3'd3,
    MODE_ANDN = 3'd4
  } count_mode_t;

  // per-beat result of the word evaluation
  typedef struct packed {
    logic [ONES_W-1:0] ones;
    logic              subset_miss;
  } word_eval_t;

  // ones in a 32-bit value: pairwise, nibble and byte folding
  function automatic logic [5:0] ones32(input logic [31:0] v);
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
    s1 = v - ((v >> 1) & 32'h5555_5555);
    s2 = (s1 & 32'h3333_3333) + ((s1 >> 2) & 32'h3333_3333);
    s3 = (s2 + (s2 >> 4)) & 32'h0F0F_0F0F;
    return 6'(s3[7:0]) + 6'(s3[15:8]) + 6'(s3[23:16]) + 6'(s3[31:24]);
  endfunction

  // ones in a 64-bit word
  function automatic logic [ONES_W-1:0] ones64(input logic [WORD_W-1:0] v);
    return ONES_W'(ones32(v[31:0])) + ONES_W'(ones32(v[63:32]));
  endfunction

endpackage

// File: rtl/core/bitset_pair_popcount_top.sv
// ----------------------------------------------------------------------------
// bitset_pair_popcount_top
// Streams two bit sets as 64-bit word pairs, counts the ones of a selected
// bitwise operation and tests whether the first set is a subset of the second.
// ----------------------------------------------------------------------------
// Usage:
//   - Input beats carry one word pair each; in_last_word closes a set pair
//     and in_valid_bytes picks how many low bytes of that last word count.
//   - One result beat per set pair: the saturating count and the subset flag.
//   - cfg_wr_en/cfg_wr_data load the operation mode; write it between set
//     pairs only.
//   - A beat lands in the input register and is counted from there; for a
//     last word the result then lands in the output register, and out_valid
//     rises as that register is written, after any held result is taken.
//   - Throughput: one beat per cycle while no last word waits on a held result;
//     the 64-bit popcount plus accumulate of one word is logic between the two registers.
//   - A stalled receiver holds the result; non-last beats keep flowing into
//     the accumulator, and a second last word waits in the input register
//     until the held result is taken.
//   - Reset clears the mode to AND, the count to zero and the subset flag to
//     one, and drops both valids.
// ----------------------------------------------------------------------------
module bitset_pair_popcount_top
  import bpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [MODE_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WORD_W-1:0]   in_word_a,
  input  logic [WORD_W-1:0]   in_word_b,
  input  logic [VBYTES_W-1:0] in_valid_bytes,
  input  logic                in_last_word,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  out_bit_count,
  output logic                out_is_subset
);

  logic [MODE_W-1:0]   mode_r;
  logic                s1_valid_r;
  logic [WORD_W-1:0]   s1_word_a_r;
  logic [WORD_W-1:0]   s1_word_b_r;
  logic [VBYTES_W-1:0] s1_valid_bytes_r;
  logic                s1_last_r;
  logic [COUNT_W-1:0]  running_count_r;
  logic [COUNT_W-1:0]  running_count_nxt;
  logic                subset_so_far_r;
  logic                subset_so_far_nxt;
  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_bit_count_r;
  logic                out_is_subset_r;
  logic                s1_go;
  logic                in_fire;
  logic [COUNT_W:0]    sum;
  word_eval_t          eval;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_AND;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // handshake: stage 1 drains unless its last beat meets a held result
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_a_r      <= in_word_a;
      s1_word_b_r      <= in_word_b;
      s1_valid_bytes_r <= in_valid_bytes;
      s1_last_r        <= in_last_word;
    end
  end

  bpp_word_eval u_word_eval (
    .count_mode  (mode_r),
    .word_a      (s1_word_a_r),
    .word_b      (s1_word_b_r),
    .valid_bytes (s1_valid_bytes_r),
    .last_word   (s1_last_r),
    .result      (eval)
  );

  // saturating accumulate and subset tracking
  assign sum = (COUNT_W+1)'(running_count_r) + (COUNT_W+1)'(eval.ones);

  always_comb begin
    running_count_nxt = (sum > (COUNT_W+1)'(COUNT_LIMIT)) ? COUNT_W'(COUNT_LIMIT)
                                                         : sum[COUNT_W-1:0];
    subset_so_far_nxt = subset_so_far_r && !eval.subset_miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_count_r <= '0;
      subset_so_far_r <= 1'b1;
    end else if (s1_go) begin
      if (s1_last_r) begin
        running_count_r <= '0;
        subset_so_far_r <= 1'b1;
      end else begin
        running_count_r <= running_count_nxt;
        subset_so_far_r <= subset_so_far_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_bit_count_r <= running_count_nxt;
      out_is_subset_r <= subset_so_far_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bit_count = out_bit_count_r;
  assign out_is_subset = out_is_subset_r;

  // checks
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    running_count_r <= COUNT_W'(COUNT_LIMIT))
    else $error("running count above limit");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> out_valid_r)
    else $error("last beat did not produce a result");

  a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (running_count_r == '0 && subset_so_far_r))
    else $error("state not cleared after result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_go && s1_last_r))
    else $error("held result overwritten");

endmodule

// File: rtl/core/bpp_word_eval.sv
// ----------------------------------------------------------------------------
// bpp_word_eval
// Counts the ones of the selected operation over the valid bytes of one word
// pair and flags a bit of the first word that is missing from the second.
// ----------------------------------------------------------------------------
module bpp_word_eval
  import bpp_pkg::*;
(
  input  logic [MODE_W-1:0]   count_mode,
  input  logic [WORD_W-1:0]   word_a,
  input  logic [WORD_W-1:0]   word_b,
  input  logic [VBYTES_W-1:0] valid_bytes,
  input  logic                last_word,
  output word_eval_t          result
);

  logic [WORD_W-1:0] byte_mask;
  logic [WORD_W-1:0] op_word;

  // only the low valid bytes take part on the final beat
  always_comb begin
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      byte_mask[i*8 +: 8] = (!last_word || (valid_bytes > VBYTES_W'(i))) ? 8'hFF : 8'h00;
    end
  end

  // operation decode; unused codes contribute nothing
  always_comb begin
    unique case (count_mode)
      MODE_AND:  op_word = word_a & word_b;
      MODE_OR:   op_word = word_a | word_b;
      MODE_XNOR: op_word = ~(word_a ^ word_b);
      MODE_XOR:  op_word = word_a ^ word_b;
      MODE_ANDN: op_word = word_a & ~word_b;
      default:   op_word = '0;
    endcase
  end

  assign result.ones        = ones64(op_word & byte_mask);
  assign result.subset_miss = |(word_a & ~word_b & byte_mask);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit set pair counter: a queue-fed driver streams
// word pair beats, a shadow model of the count and subset flag predicts each
// result, and a monitor compares result beats under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import bpp_pkg::*;

  // mode codes beyond the defined operations
  localparam logic [MODE_W-1:0] MODE_RSVD_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_HI  = 3'd7;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYC  = 4;
  localparam int NUM_PHASES  = 4;
  localparam int CHUNKS      = 4;
  localparam int CHUNK_BEATS = 110;

  typedef struct {
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
    logic [VBYTES_W-1:0] vbytes;
    logic                last;
  } pair_beat_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               subset;
  } pair_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [MODE_W-1:0]   cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [WORD_W-1:0]   in_word_a = '0;
  logic [WORD_W-1:0]   in_word_b = '0;
  logic [VBYTES_W-1:0] in_valid_bytes = '0;
  logic                in_last_word = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COUNT_W-1:0]  out_bit_count;
  logic                out_is_subset;

  pair_beat_t   pair_q[$];
  pair_result_t result_q[$];
  pair_beat_t   drv_beat;
  pair_result_t got_res;

  // shadow of the block state
  logic [MODE_W-1:0] mode_shadow = MODE_AND;
  int unsigned       run_count = 0;
  logic              subset_run = 1'b1;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;
  int beat_cnt = 0;
  int result_cnt = 0;
  int mode_writes = 0;
  int sat_cnt = 0;
  int subset_cnt = 0;
  int cyc = 0;

  bitset_pair_popcount_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word_a      (in_word_a),
    .in_word_b      (in_word_b),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bit_count  (out_bit_count),
    .out_is_subset  (out_is_subset)
  );

  // clock and reset
  initial begin
    rst_n <= 1'b0;
    fork
      forever #1 clk = ~clk;
      begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("Some tests failed");
      $finish;
    end
  end

  // bitwise operation of one word pair under a mode
  function automatic logic [WORD_W-1:0] mode_op(input logic [MODE_W-1:0] mode,
                                               input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    case (mode)
      MODE_AND:  return a & b;
      MODE_OR:   return a | b;
      MODE_XNOR: return ~(a ^ b);
      MODE_XOR:  return a ^ b;
      MODE_ANDN: return a & ~b;
      default:   return '0;
    endcase
  endfunction

  // fold one accepted beat into the shadow count, emit expectation on last
  function automatic void count_pair(input pair_beat_t bt);
    logic [WORD_W-1:0] mask;
    int unsigned       sum;
    if (!bt.last || bt.vbytes >= BYTES_PER_WORD)
      mask = '1;
    else
      mask = (64'd1 << (8 * bt.vbytes)) - 64'd1;
    sum = run_count + $countones(mode_op(mode_shadow, bt.word_a, bt.word_b) & mask);
    if (sum > COUNT_LIMIT)
      sum = COUNT_LIMIT;
    run_count = sum;
    if ((bt.word_a & bt.word_b & mask) != (bt.word_a & mask))
      subset_run = 1'b0;
    if (bt.last) begin
      result_q.push_back('{count: COUNT_W'(run_count), subset: subset_run});
      if (run_count == COUNT_LIMIT)
        sat_cnt++;
      if (subset_run)
        subset_cnt++;
      run_count = 0;
      subset_run = 1'b1;
    end
  endfunction

  // driver: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        count_pair(drv_beat);
        beat_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_beat = pair_q.pop_front();
          in_word_a      <= drv_beat.word_a;
          in_word_b      <= drv_beat.word_b;
          in_valid_bytes <= drv_beat.vbytes;
          in_last_word   <= drv_beat.last;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_cnt++;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: bit_count %0d is_subset %0d",
                 out_bit_count, out_is_subset);
          err_cnt++;
        end else begin
          got_res = result_q.pop_front();
          if (out_bit_count !== got_res.count) begin
            $error("bit_count mismatch: expected %0d actual %0d",
                   got_res.count, out_bit_count);
            err_cnt++;
          end
          if (out_is_subset !== got_res.subset) begin
            $error("is_subset mismatch: expected %0d actual %0d",
                   got_res.subset, out_is_subset);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                           input logic [VBYTES_W-1:0] vb, input logic last);
    pair_q.push_back('{word_a: a, word_b: b, vbytes: vb, last: last});
  endtask

  // hold the sender until every beat is taken and every result is back
  task automatic drain();
    while (pair_q.size() != 0 || in_valid || result_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // mode writes only once the block has gone quiet
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mode_shadow = mode;
    mode_writes++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // one random set pair; mostly short, a few long enough to saturate
  task automatic push_set(output int len);
    int                  pick;
    int                  style;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [VBYTES_W-1:0] vb;
    pick  = $urandom_range(99);
    style = $urandom_range(3);
    if (pick < 85)
      len = $urandom_range(1, 6);
    else if (pick < 95)
      len = $urandom_range(7, 20);
    else
      len = $urandom_range(60, 72);
    for (int i = 0; i < len; i++) begin
      a = rand_word();
      b = rand_word();
      case (style)
        1: a = a & b;
        2: begin
          a = '1;
          b = '1;
          if ($urandom_range(9) == 0)
            b = ~(64'd1 << $urandom_range(63));
        end
        3: a = a & rand_word() & rand_word();
        default: ;
      endcase
      if (i == len - 1 && $urandom_range(99) < 80)
        vb = VBYTES_W'($urandom_range(1, BYTES_PER_WORD));
      else
        vb = VBYTES_W'($urandom_range(0, 15));
      push_pair(a, b, vb, i == len - 1);
    end
  endtask

  // stimulus
  initial begin
    int n;
    int len;
    while (!rst_n) @(posedge clk);

    // reset mode, full words, empty and oversized byte counts
    push_pair('1, '1, 4'd8, 1'b1);
    push_pair('1, '0, 4'd0, 1'b1);
    push_pair('1, '0, 4'd15, 1'b1);
    push_pair('1, '1, 4'd0, 1'b0);
    push_pair(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 4'd1, 1'b1);
    push_pair('0, '0, 4'd8, 1'b1);
    push_pair('1, 64'h00FF_FFFF_FFFF_FFFF, 4'd7, 1'b1);

    // each operation in turn, then the reserved codes
    write_mode(MODE_OR);
    push_pair('0, '1, 4'd8, 1'b1);
    push_pair(64'h1, '0, 4'd9, 1'b1);
    write_mode(MODE_XNOR);
    push_pair('0, '0, 4'd3, 1'b1);
    push_pair(rand_word(), rand_word(), 4'd8, 1'b1);
    write_mode(MODE_XOR);
    push_pair('1, '0, 4'd8, 1'b1);
    push_pair(64'h8000_0000_0000_0000, '0, 4'd8, 1'b1);
    write_mode(MODE_ANDN);
    push_pair('1, 64'h5555_5555_5555_5555, 4'd8, 1'b1);
    write_mode(MODE_RSVD_LO);
    push_pair('1, '1, 4'd8, 1'b1);
    write_mode(MODE_RSVD_MID);
    push_pair('1, 64'h0F, 4'd2, 1'b1);
    write_mode(MODE_RSVD_HI);
    push_pair('1, '1, 4'd8, 1'b0);
    push_pair('1, '0, 4'd1, 1'b1);

    // mode switched inside a set pair
    write_mode(MODE_XOR);
    push_pair('1, '0, 4'd0, 1'b0);
    push_pair(64'hF0, 64'h0F, 4'd0, 1'b0);
    write_mode(MODE_AND);
    push_pair('1, '1, 4'd4, 1'b1);

    // random phases: none, sender idle, receiver stall, both
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = 0; k < CHUNKS; k++) begin
        write_mode(MODE_W'((p * CHUNKS + k) % (int'(MODE_RSVD_HI) + 1)));
        send_idle_pct  = (p == 1) ? 60 : (p == 3) ? 32 : 0;
        recv_stall_pct = (p == 2) ? 60 : (p == 3) ? 32 : 0;
        n = 0;
        while (n < CHUNK_BEATS) begin
          push_set(len);
          n += len;
        end
      end
    end

    // wait out the tail
    drain();
    repeat (10) @(posedge clk);
    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      err_cnt++;
    end

    $display("%0d word pair beats, %0d results checked, %0d mode writes",
             beat_cnt, result_cnt, mode_writes);
    $display("%0d saturated counts, %0d subset hits, %0d mismatches",
             sat_cnt, subset_cnt, err_cnt);
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
